@@ rtl/core/ird_pkg.sv @@
package ird_pkg;

	localparam int DEPTH = 8;
	localparam int DATA_W = 32;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 4;

	typedef enum logic [1:0] {
		MODE_PUSH_REAR  = 2'd0,
		MODE_POP_FRONT  = 2'd1,
		MODE_POP_REAR   = 2'd2,
		MODE_PEEK_FRONT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-item result fields known at accept time
	typedef struct packed {
		status_t           status;
		logic              rd;
		logic              is_empty;
		logic              is_full;
		logic [OCC_W-1:0]  occupancy;
	} ctl_t;

endpackage

@@ rtl/core/ird_ram.sv @@
module ird_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/ird_ctrl.sv @@
module ird_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [1:0]                 mode,
	output ird_pkg::ctl_t              ctl,
	output logic                       ram_we,
	output logic                       ram_re,
	output logic [ird_pkg::PTR_W-1:0]  ram_waddr,
	output logic [ird_pkg::PTR_W-1:0]  ram_raddr
);
	import ird_pkg::*;

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             full, empty;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
	endfunction

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = tail_q;
		ram_raddr  = head_q;
		ctl.status = ST_DONE;
		ctl.rd     = 1'b0;
		unique case (mode_t'(mode))
			MODE_PUSH_REAR: begin
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ram_we = take;
					tail_d = ptr_next(tail_q);
					cnt_d  = cnt_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ram_re = take;
					ctl.rd = 1'b1;
					head_d = ptr_next(head_q);
					cnt_d  = cnt_q - CNT_W'(1);
				end
			end
			MODE_POP_REAR: begin
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ram_re    = take;
					ctl.rd    = 1'b1;
					ram_raddr = ptr_prev(tail_q);
					tail_d    = ptr_prev(tail_q);
					cnt_d     = cnt_q - CNT_W'(1);
				end
			end
			MODE_PEEK_FRONT: begin
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ram_re = take;
					ctl.rd = 1'b1;
				end
			end
		endcase
		ctl.is_empty  = (cnt_d == '0);
		ctl.is_full   = (cnt_d == CNT_W'(DEPTH));
		ctl.occupancy = OCC_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CNT_W'(DEPTH)) |-> head_q == tail_q)
		else $error("pointers apart with deque empty or full");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode_t'(mode) == MODE_PUSH_REAR && !full)
		|=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("push did not raise count");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("read and write in one transfer");

endmodule

@@ rtl/core/input_restricted_deque.sv @@
// input_restricted_deque: circular-buffer deque, insert at the rear only,
// remove from the front or the rear, or peek at the front.
// input channel: in_valid / in_stall carry mode and data; a transfer happens
// at a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry status, value, is_empty,
// is_full and occupancy; exactly one result per input transfer, in order.
// path: the element memory read registers at the transfer edge, then the
// output register loads the result unless out_stall holds it, and the result
// transfers from the output register.
// throughput: one item per cycle while in_stall stays low; the pointer and
// count update in the accept cycle, so the next item sees the new state with no bubble.
// a pushed element is written at its transfer edge and is readable by the
// very next item.
// reset (arst_n low) empties the deque, clears both pointers and drops all
// pending results; the element memory is not cleared.
// when out_stall holds the output register and a result waits behind it,
// in_stall rises until the output drains.
module input_restricted_deque (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  mode,
	input  logic signed [ird_pkg::DATA_W-1:0] data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic signed [ird_pkg::DATA_W-1:0] value,
	output logic                        is_empty,
	output logic                        is_full,
	output logic [ird_pkg::OCC_W-1:0]   occupancy
);
	import ird_pkg::*;

	logic              take, adv_s1;
	ctl_t              ctl, ctl_s1;
	logic              valid_s1;
	logic              ram_we, ram_re;
	logic [PTR_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] value_q;
	logic              is_empty_q, is_full_q;
	logic [OCC_W-1:0]  occupancy_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	ird_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mode      (mode),
		.ctl       (ctl),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	ird_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q    <= ctl_s1.status;
			value_q     <= ctl_s1.rd ? ram_rdata : '0;
			is_empty_q  <= ctl_s1.is_empty;
			is_full_q   <= ctl_s1.is_full;
			occupancy_q <= ctl_s1.occupancy;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign is_empty  = is_empty_q;
	assign is_full   = is_full_q;
	assign occupancy = occupancy_q;

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_t'(status) == ST_EMPTY) |-> is_empty)
		else $error("empty rejection without empty flag");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_t'(status) == ST_FULL) |-> is_full)
		else $error("full rejection without full flag");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1 && out_valid_q)
		else $error("result dropped while stalled");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_t'(status) != ST_DONE) |-> value == '0)
		else $error("rejected item carries a value");

endmodule

@@ verif/input_restricted_deque_tb.sv @@
module input_restricted_deque_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ird_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int LONG_HOLD = 64;
	localparam int PHASE_LEN = 115;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] value;
		logic                     is_empty;
		logic                     is_full;
		logic [OCC_W-1:0]         occupancy;
	} deque_result_t;

	class deque_scoreboard;
		logic signed [DATA_W-1:0] store [DEPTH];
		int front_idx;
		int rear_idx;
		int held;
		int mismatches;
		deque_result_t outcome_q[$];

		function new();
			front_idx = 0;
			rear_idx = 0;
			held = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// advance the deque state for one accepted request and queue its outcome
		function void note_request(mode_t m, logic signed [DATA_W-1:0] d);
			deque_result_t r;
			r.status = ST_DONE;
			r.value = '0;
			if (m == MODE_PUSH_REAR) begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					store[rear_idx] = d;
					rear_idx = (rear_idx + 1) % DEPTH;
					held++;
				end
			end else if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				case (m)
					MODE_POP_FRONT: begin
						r.value = store[front_idx];
						front_idx = (front_idx + 1) % DEPTH;
						held--;
					end
					MODE_POP_REAR: begin
						rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
						r.value = store[rear_idx];
						held--;
					end
					default: begin
						r.value = store[front_idx];
					end
				endcase
			end
			r.is_empty = (held == 0);
			r.is_full = (held == DEPTH);
			r.occupancy = OCC_W'(held);
			outcome_q.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] val,
				logic emp, logic ful, logic [OCC_W-1:0] occ);
			deque_result_t e;
			if (outcome_q.size() == 0) begin
				$error("result transfer with nothing outstanding");
				mismatches++;
				return;
			end
			e = outcome_q.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				mismatches++;
			end
			if (val !== e.value) begin
				$error("value: expected %0d, got %0d", e.value, val);
				mismatches++;
			end
			if (emp !== e.is_empty) begin
				$error("is_empty: expected %0d, got %0d", e.is_empty, emp);
				mismatches++;
			end
			if (ful !== e.is_full) begin
				$error("is_full: expected %0d, got %0d", e.is_full, ful);
				mismatches++;
			end
			if (occ !== e.occupancy) begin
				$error("occupancy: expected %0d, got %0d", e.occupancy, occ);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] mode;
	logic signed [DATA_W-1:0] data;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic signed [DATA_W-1:0] value;
	logic is_empty;
	logic is_full;
	logic [OCC_W-1:0] occupancy;

	bit quiet = 1'b0;
	bit rx_hold_req = 1'b0;
	int idle_cycles = 0;
	deque_scoreboard sb = new();

	input_restricted_deque i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.data      (data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.value     (value),
		.is_empty  (is_empty),
		.is_full   (is_full),
		.occupancy (occupancy)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(mode_t'(mode), data);
			if (out_valid && !out_stall)
				sb.check_result(status, value, is_empty, is_full, occupancy);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side: random stall per transfer, one long hold on request
	initial begin
		int wait_n;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				wait_n = LONG_HOLD;
				rx_hold_req = 1'b0;
			end else if (quiet) begin
				wait_n = 0;
			end else begin
				wait_n = $urandom_range(0, 7);
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_word();
		logic signed [DATA_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = 32'h7FFF_FFFF;
			1: w = 32'h8000_0000;
			2: w = '0;
			3: w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic mode_t pick_mode(int push_pct);
		mode_t m;
		if ($urandom_range(0, 99) < push_pct) begin
			m = MODE_PUSH_REAR;
		end else begin
			case ($urandom_range(0, 2))
				0: m = MODE_POP_FRONT;
				1: m = MODE_POP_REAR;
				default: m = MODE_PEEK_FRONT;
			endcase
		end
		return m;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send(input mode_t m, input logic signed [DATA_W-1:0] d);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data <= d;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int push_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PUSH_REAR;
		data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// operations on an empty deque
		send(MODE_POP_FRONT, '1);
		send(MODE_POP_REAR, '1);
		send(MODE_PEEK_FRONT, '1);
		// fill to the top with extreme values
		send(MODE_PUSH_REAR, 32'h7FFF_FFFF);
		send(MODE_PUSH_REAR, 32'h8000_0000);
		send(MODE_PUSH_REAR, '0);
		send(MODE_PUSH_REAR, '1);
		send(MODE_PUSH_REAR, 32'h5555_5555);
		send(MODE_PUSH_REAR, 32'hAAAA_AAAA);
		send(MODE_PUSH_REAR, 32'h0000_0001);
		send(MODE_PUSH_REAR, rand_word());
		send(MODE_PUSH_REAR, 32'h1234_5678);
		send(MODE_PEEK_FRONT, '0);
		send(MODE_POP_FRONT, '0);
		send(MODE_POP_REAR, '0);
		// pointers wrap, last element leaves from the front away from slot zero
		send(MODE_PUSH_REAR, 32'hDEAD_BEEF);
		send(MODE_PUSH_REAR, 32'h8000_0001);
		repeat (3) send(MODE_POP_FRONT, '0);
		repeat (4) send(MODE_POP_REAR, '0);
		send(MODE_POP_FRONT, '0);
		send(MODE_POP_REAR, '0);
		send(MODE_PEEK_FRONT, '0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			quiet = (ph % 4 == 3);
			push_pct = (ph % 3 == 0) ? 70 : ((ph % 3 == 1) ? 30 : 50);
			if (ph == 3)
				rx_hold_req = 1'b1;
			if (ph == 6)
				drain();
			repeat (PHASE_LEN) send(pick_mode(push_pct), rand_word());
		end
		quiet = 1'b0;

		drain();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
